@@ src/hsdtm_pkg.sv @@
// ----------------------------------------------------------------------------
// hsdtm_pkg: shared constants, types and helpers
// Widths, CORDIC angle table and saturation for the heading/speed/depth mixer.
// ----------------------------------------------------------------------------
package hsdtm_pkg;

    // Default and maximum CORDIC depth
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;

    // Datapath widths
    localparam int NUM_W  = 34;   // num / den in Q28
    localparam int XY_W   = 37;   // CORDIC x/y with growth margin
    localparam int Z_W    = 27;   // CORDIC angle, 1/65536 degree
    localparam int HEAD_W = 15;   // heading, 1/64 degree
    localparam int ATAN_W = 22;

    // Angle constants
    localparam int DEG_ONE   = 65536;
    localparam int DEG_HALF  = 180 * DEG_ONE;
    localparam int DEG_FULL  = 360 * DEG_ONE;
    localparam int HEAD_FULL = 23040;
    localparam int HEAD_HALF = 11520;
    localparam int ROUND_OFS = 512;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_DEG [CORDIC_MAX] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // Configuration register map
    typedef enum logic [2:0] {
        CFG_DEPTH_SP   = 3'd0,
        CFG_SPEED_SP   = 3'd1,
        CFG_HEADING_SP = 3'd2,
        CFG_HEAD_GAIN  = 3'd3,
        CFG_SPEED_GAIN = 3'd4,
        CFG_DEPTH_GAIN = 3'd5,
        CFG_HEAD_SHARE = 3'd6,
        CFG_SPEED_SHR  = 3'd7
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SUM_W      = 44;

    // Clamp a wide signed value to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [15:0] r;
        if (v > 44'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -44'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ src/heading_speed_depth_thrust_mixer.sv @@
// ----------------------------------------------------------------------------
// heading_speed_depth_thrust_mixer: proportional controller with thrust mix
// Yaw from quaternion via CORDIC atan2, heading/speed/depth errors scaled by
// Q8.8 gains, mixed into port, starboard and vertical thrust, saturated.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------------
//  sample    in         start & !busy             i_quat_w/x/y/z, i_depth_measured,
//                                                 i_speed_measured
//  thrust    out        o_strobe (one cycle)      o_port_thrust, o_starboard_thrust,
//                                                 o_vertical_thrust
//  config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
//  Throughput: one sample per clock, every clock.
//  From accept to strobe a sample passes stages A and B, the CORDIC pre-rotation,
//  micro-rotation, wrap and round registers, then stages F, G and H.
//  Reset: synchronous, active low; clears all valid bits and loads register
//  defaults. busy is high only until the first clock after reset releases.
//  The result strobe cannot be held off, so the pipeline never stalls.
//
module heading_speed_depth_thrust_mixer #(
    parameter int CORDIC_STAGES = hsdtm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [15:0]                    i_quat_w,
    input  logic signed [15:0]                    i_quat_x,
    input  logic signed [15:0]                    i_quat_y,
    input  logic signed [15:0]                    i_quat_z,
    input  logic signed [16:0]                    i_depth_measured,
    input  logic signed [12:0]                    i_speed_measured,
    // thrust channel
    output logic                                  o_strobe,
    output logic signed [15:0]                    o_port_thrust,
    output logic signed [15:0]                    o_starboard_thrust,
    output logic signed [15:0]                    o_vertical_thrust,
    // config channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hsdtm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hsdtm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int NW  = hsdtm_pkg::NUM_W;
    localparam int HW  = hsdtm_pkg::HEAD_W;
    localparam int SW  = hsdtm_pkg::SUM_W;
    // measurement delay matching the CORDIC block plus its input stage
    localparam int DLY = CORDIC_STAGES + 4;

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    logic               r_run;
    logic signed [16:0] r_depth_sp;
    logic signed [12:0] r_speed_sp;
    logic [14:0]        r_heading_sp;
    logic [15:0]        r_head_gain;
    logic [15:0]        r_speed_gain;
    logic [15:0]        r_depth_gain;
    logic [8:0]         r_head_share;
    logic [8:0]         r_speed_share;

    logic accept;
    logic cfg_wr;

    assign busy        = !r_run;
    assign o_cfg_ready = r_run;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Registered flag that opens the sample and config channels once reset releases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    // Register file: user writes only while the pipeline is empty; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_sp    <= '0;
            r_speed_sp    <= '0;
            r_heading_sp  <= '0;
            r_head_gain   <= 16'd256;
            r_speed_gain  <= 16'd2560;
            r_depth_gain  <= 16'd12800;
            r_head_share  <= 9'd128;
            r_speed_share <= 9'd128;
        end else if (cfg_wr) begin
            case (hsdtm_pkg::t_cfg_reg'(i_cfg_index))
                hsdtm_pkg::CFG_DEPTH_SP:   r_depth_sp    <= i_cfg_data[16:0];
                hsdtm_pkg::CFG_SPEED_SP:   r_speed_sp    <= i_cfg_data[12:0];
                hsdtm_pkg::CFG_HEADING_SP: r_heading_sp  <= i_cfg_data[14:0];
                hsdtm_pkg::CFG_HEAD_GAIN:  r_head_gain   <= i_cfg_data[15:0];
                hsdtm_pkg::CFG_SPEED_GAIN: r_speed_gain  <= i_cfg_data[15:0];
                hsdtm_pkg::CFG_DEPTH_GAIN: r_depth_gain  <= i_cfg_data[15:0];
                hsdtm_pkg::CFG_HEAD_SHARE: r_head_share  <= i_cfg_data[8:0];
                hsdtm_pkg::CFG_SPEED_SHR:  r_speed_share <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Share times gain depends on configuration only: recompute every clock
    logic [24:0] r_head_wt, r_speed_wt;
    always_ff @(posedge i_clk) begin
        r_head_wt  <= 25'(r_head_share) * 25'(r_head_gain);
        r_speed_wt <= 25'(r_speed_share) * 25'(r_speed_gain);
    end

    // ------------------------------------------------------------------
    // Stage A: quaternion products
    // ------------------------------------------------------------------
    logic               r_a_vld;
    logic signed [31:0] r_wz, r_xy, r_yy, r_zz;
    logic signed [16:0] r_a_dm;
    logic signed [12:0] r_a_sm;

    always_ff @(posedge i_clk) begin
        r_wz   <= 32'(i_quat_w) * 32'(i_quat_z);
        r_xy   <= 32'(i_quat_x) * 32'(i_quat_y);
        r_yy   <= 32'(i_quat_y) * 32'(i_quat_y);
        r_zz   <= 32'(i_quat_z) * 32'(i_quat_z);
        r_a_dm <= i_depth_measured;
        r_a_sm <= i_speed_measured;
    end

    // ------------------------------------------------------------------
    // Stage B: num = 2(wz+xy), den = 2^28 - 2(yy+zz)
    // ------------------------------------------------------------------
    localparam logic signed [NW-1:0] DEN_ONE = NW'(1) <<< 28;

    logic               r_b_vld;
    logic signed [NW-1:0] r_b_num, r_b_den;
    logic signed [NW-1:0] sum_wx, sum_yz;

    assign sum_wx = NW'(r_wz) + NW'(r_xy);
    assign sum_yz = NW'(r_yy) + NW'(r_zz);

    always_ff @(posedge i_clk) begin
        r_b_num <= sum_wx <<< 1;
        r_b_den <= DEN_ONE - (sum_yz <<< 1);
    end

    // Measurements ride alongside the CORDIC
    logic signed [16:0] r_dm_dly [DLY];
    logic signed [12:0] r_sm_dly [DLY];

    always_ff @(posedge i_clk) begin
        r_dm_dly[0] <= r_a_dm;
        r_sm_dly[0] <= r_a_sm;
        for (int k = 1; k < DLY; k++) begin
            r_dm_dly[k] <= r_dm_dly[k-1];
            r_sm_dly[k] <= r_sm_dly[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Heading: pipelined CORDIC atan2
    // ------------------------------------------------------------------
    logic          hd_vld;
    logic [HW-1:0] hd_heading;

    hsdtm_cordic #(
        .STAGES    (CORDIC_STAGES)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_b_vld),
        .i_num     (r_b_num),
        .i_den     (r_b_den),
        .o_vld     (hd_vld),
        .o_heading (hd_heading)
    );

    // ------------------------------------------------------------------
    // Stage F: errors; flip side sign past half a turn
    // ------------------------------------------------------------------
    logic               r_f_vld;
    logic signed [16:0] r_f_pt;
    logic signed [13:0] r_f_se;
    logic signed [17:0] r_f_de;

    logic signed [16:0] he;
    logic               he_near;

    assign he      = $signed({2'b00, r_heading_sp}) - $signed({2'b00, hd_heading});
    assign he_near = (he > -17'(hsdtm_pkg::HEAD_HALF)) && (he < 17'(hsdtm_pkg::HEAD_HALF));

    always_ff @(posedge i_clk) begin
        r_f_pt <= he_near ? -he : he;
        r_f_se <= 14'(r_speed_sp) - 14'(r_sm_dly[DLY-1]);
        r_f_de <= 18'(r_depth_sp) - 18'(r_dm_dly[DLY-1]);
    end

    // ------------------------------------------------------------------
    // Stage G: weighted terms
    // ------------------------------------------------------------------
    logic               r_g_vld;
    logic signed [42:0] r_g_head;
    logic signed [39:0] r_g_speed;
    logic signed [34:0] r_g_vert;

    always_ff @(posedge i_clk) begin
        r_g_head  <= 43'($signed({1'b0, r_head_wt}))    * 43'(r_f_pt);
        r_g_speed <= 40'($signed({1'b0, r_speed_wt}))   * 40'(r_f_se);
        r_g_vert  <= 35'($signed({1'b0, r_depth_gain})) * 35'(r_f_de);
    end

    // ------------------------------------------------------------------
    // Stage H: mix, scale down, saturate into output registers
    // ------------------------------------------------------------------
    logic signed [SW-1:0] port_sum, star_sum, port_sh, star_sh, vert_sh;

    assign port_sum = SW'(r_g_speed) + SW'(r_g_head);
    assign star_sum = SW'(r_g_speed) - SW'(r_g_head);
    assign port_sh  = port_sum >>> 16;
    assign star_sh  = star_sum >>> 16;
    assign vert_sh  = SW'(r_g_vert) >>> 8;

    logic               r_o_vld;
    logic signed [15:0] r_port, r_star, r_vert;

    always_ff @(posedge i_clk) begin
        r_port <= hsdtm_pkg::sat16(port_sh);
        r_star <= hsdtm_pkg::sat16(star_sh);
        r_vert <= hsdtm_pkg::sat16(vert_sh);
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
            r_b_vld <= r_a_vld;
            r_f_vld <= hd_vld;
            r_g_vld <= r_f_vld;
            r_o_vld <= r_g_vld;
        end
    end

    assign o_strobe           = r_o_vld;
    assign o_port_thrust      = r_port;
    assign o_starboard_thrust = r_star;
    assign o_vertical_thrust  = r_vert;

endmodule

@@ src/hsdtm_cordic.sv @@
// ----------------------------------------------------------------------------
// hsdtm_cordic: pipelined vectoring CORDIC for atan2
// Heading of (den, num) in 1/64 degree, wrapped into [0, 23040).
// ----------------------------------------------------------------------------
module hsdtm_cordic #(
    parameter int STAGES = hsdtm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic signed [hsdtm_pkg::NUM_W-1:0]     i_num,
    input  logic signed [hsdtm_pkg::NUM_W-1:0]     i_den,
    output logic                                   o_vld,
    output logic        [hsdtm_pkg::HEAD_W-1:0]    o_heading
);
    localparam int XW = hsdtm_pkg::XY_W;
    localparam int ZW = hsdtm_pkg::Z_W;
    localparam int HW = hsdtm_pkg::HEAD_W;

    // Stage arrays: index 0 is the pre-rotation register
    logic                 r_vld  [STAGES+1];
    logic                 r_zero [STAGES+1];
    logic signed [XW-1:0] r_x    [STAGES+1];
    logic signed [XW-1:0] r_y    [STAGES+1];
    logic signed [ZW-1:0] r_z    [STAGES+1];

    logic                 r_w_vld, r_w_zero;
    logic signed [ZW-1:0] r_w_z;
    logic                 r_h_vld;
    logic        [HW-1:0] r_h;

    logic signed [XW-1:0] den_x, num_x;
    logic                 den_neg;
    logic signed [ZW-1:0] z_wrap;
    logic signed [ZW-1:0] z_rnd;
    logic        [HW-1:0] h_raw, h_fix;

    assign den_x   = XW'(i_den);
    assign num_x   = XW'(i_num);
    assign den_neg = i_den[hsdtm_pkg::NUM_W-1];

    // Pre-rotate into the right half plane
    always_ff @(posedge i_clk) begin
        r_x[0]    <= den_neg ? -den_x : den_x;
        r_y[0]    <= den_neg ? -num_x : num_x;
        r_z[0]    <= den_neg ? ZW'(hsdtm_pkg::DEG_HALF) : '0;
        r_zero[0] <= (i_num == '0) && (i_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_w_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_w_vld <= r_vld[STAGES];
            r_h_vld <= r_w_vld;
        end
    end

    // One micro-rotation per stage, driving y toward zero
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] ang;
        assign xs  = r_x[i] >>> i;
        assign ys  = r_y[i] >>> i;
        assign ang = ZW'(hsdtm_pkg::ATAN_DEG[i]);

        always_ff @(posedge i_clk) begin
            if (!r_y[i][XW-1]) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + ang;
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - ang;
            end
            r_zero[i+1] <= r_zero[i];
        end
    end

    // Fold negative angles into [0, 360)
    assign z_wrap = r_z[STAGES][ZW-1] ? r_z[STAGES] + ZW'(hsdtm_pkg::DEG_FULL)
                                      : r_z[STAGES];

    always_ff @(posedge i_clk) begin
        r_w_z    <= z_wrap;
        r_w_zero <= r_zero[STAGES];
    end

    // Round to 1/64 degree, half up; 360 wraps to 0
    assign z_rnd = r_w_z + ZW'(hsdtm_pkg::ROUND_OFS);
    assign h_raw = z_rnd[HW+9:10];
    assign h_fix = (h_raw >= HW'(hsdtm_pkg::HEAD_FULL)) ? h_raw - HW'(hsdtm_pkg::HEAD_FULL)
                                                        : h_raw;

    always_ff @(posedge i_clk) begin
        r_h <= r_w_zero ? '0 : h_fix;
    end

    assign o_vld     = r_h_vld;
    assign o_heading = r_h;

endmodule

@@ src/hsdtm_checker.sv @@
// ----------------------------------------------------------------------------
// hsdtm_checker: port-level checks for the thrust mixer
// Fixed latency, no spurious results, and channels stay open after reset.
// ----------------------------------------------------------------------------
module hsdtm_checker #(
    parameter int CORDIC_STAGES = hsdtm_pkg::CORDIC_STAGES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_cfg_ready
);
    localparam int LAT = CORDIC_STAGES + 8;

    // Every accepted sample yields a result a fixed time later
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result missing after accepted sample");

    // No result without a sample accepted exactly the a_latency distance before
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without matching sample");

    // Once open, the sample channel stays open
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

    // Config and sample channels open together
    a_cfg_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !busy)
        else $error("config ready disagrees with busy");

endmodule

bind heading_speed_depth_thrust_mixer hsdtm_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_hsdtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_cfg_ready (o_cfg_ready)
);

@@ tb/thrust_mix_checker.sv @@
// ----------------------------------------------------------------------------
// thrust_mix_checker: scoreboard for the heading/speed/depth thrust mixer
// Watches the sample, thrust and config channels, predicts each thrust result
// from a private copy of the registers and compares it with the DUT's output.
// ----------------------------------------------------------------------------
module thrust_mix_checker #(
    parameter int STAGES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic signed [15:0]                    i_quat_w,
    input  logic signed [15:0]                    i_quat_x,
    input  logic signed [15:0]                    i_quat_y,
    input  logic signed [15:0]                    i_quat_z,
    input  logic signed [16:0]                    i_depth_measured,
    input  logic signed [12:0]                    i_speed_measured,
    input  logic                                  i_strobe,
    input  logic signed [15:0]                    i_port_thrust,
    input  logic signed [15:0]                    i_starboard_thrust,
    input  logic signed [15:0]                    i_vertical_thrust,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [hsdtm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hsdtm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hsdtm_pkg::*;

    localparam longint ANGLE_DEG   = 65536;
    localparam longint ANGLE_HALF  = 180 * ANGLE_DEG;
    localparam longint ANGLE_TURN  = 360 * ANGLE_DEG;
    localparam longint YAW_TURN    = 23040;
    localparam longint YAW_HALF    = 11520;
    localparam int     MAX_STAGES  = 24;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_STEP [MAX_STAGES] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [15:0] port;
        logic signed [15:0] starboard;
        logic signed [15:0] vertical;
    } thrust_t;

    typedef struct packed {
        logic signed [16:0] depth_sp;
        logic signed [12:0] speed_sp;
        logic [14:0]        heading_sp;
        logic [15:0]        heading_gain;
        logic [15:0]        speed_gain;
        logic [15:0]        depth_gain;
        logic [8:0]         heading_share;
        logic [8:0]         speed_share;
    } mix_regs_t;

    mix_regs_t regs;
    thrust_t   thrust_due [$];

    // Yaw in 1/64 degree from the atan2 vector (num, den), CORDIC vectoring
    function automatic logic [14:0] yaw_heading(longint num, longint den);
        longint vx, vy, ang, xs, ys, h;
        int     n;
        if (num == 0 && den == 0) begin
            return '0;
        end
        vx  = den;
        vy  = num;
        ang = 0;
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = ANGLE_HALF;
        end
        n = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
        for (int i = 0; i < n; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + ys;
                vy  = vy - xs;
                ang = ang + ATAN_STEP[i];
            end else begin
                vx  = vx - ys;
                vy  = vy + xs;
                ang = ang - ATAN_STEP[i];
            end
        end
        if (ang < 0) begin
            ang = ang + ANGLE_TURN;
        end
        h = (ang + 512) >>> 10;
        if (h >= YAW_TURN) begin
            h = h - YAW_TURN;
        end
        return h[14:0];
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic thrust_t mix_thrust(logic signed [15:0] w, logic signed [15:0] x,
                                           logic signed [15:0] y, logic signed [15:0] z,
                                           logic signed [16:0] dm, logic signed [12:0] sm,
                                           mix_regs_t r);
        longint  qw, qx, qy, qz, num, den, he, se, de, mag, pt, head_term, speed_term;
        thrust_t t;
        qw  = w;
        qx  = x;
        qy  = y;
        qz  = z;
        num = 2 * (qw * qz + qx * qy);
        den = 64'sd268435456 - 2 * (qy * qy + qz * qz);
        he  = longint'(r.heading_sp) - longint'(yaw_heading(num, den));
        se  = longint'(r.speed_sp) - longint'(sm);
        de  = longint'(r.depth_sp) - longint'(dm);
        mag = (he < 0) ? -he : he;
        // flip port/starboard once the error reaches half a turn
        pt  = (mag < YAW_HALF) ? -he : he;
        head_term  = longint'(r.heading_share) * longint'(r.heading_gain) * pt;
        speed_term = longint'(r.speed_share) * longint'(r.speed_gain) * se;
        t.port      = clamp16((head_term + speed_term) >>> 16);
        t.starboard = clamp16((speed_term - head_term) >>> 16);
        t.vertical  = clamp16((longint'(r.depth_gain) * de) >>> 8);
        return t;
    endfunction

    always @(posedge i_clk) begin
        thrust_t got;
        thrust_t want;
        if (!i_rst_n) begin
            regs.depth_sp      = '0;
            regs.speed_sp      = '0;
            regs.heading_sp    = '0;
            regs.heading_gain  = 16'd256;
            regs.speed_gain    = 16'd2560;
            regs.depth_gain    = 16'd12800;
            regs.heading_share = 9'd128;
            regs.speed_share   = 9'd128;
            thrust_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_strobe) begin
                got.port      = i_port_thrust;
                got.starboard = i_starboard_thrust;
                got.vertical  = i_vertical_thrust;
                if (thrust_due.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected thrust port %0d stbd %0d vert %0d",
                                 $time, got.port, got.starboard, got.vertical);
                    end
                    o_fail_count++;
                end else begin
                    want = thrust_due.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: thrust mismatch, expected port %0d stbd %0d vert %0d",
                                     $time, want.port, want.starboard, want.vertical);
                            $display("%0t:                    got port %0d stbd %0d vert %0d",
                                     $time, got.port, got.starboard, got.vertical);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                thrust_due.push_back(mix_thrust(i_quat_w, i_quat_x, i_quat_y, i_quat_z,
                                                i_depth_measured, i_speed_measured, regs));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEPTH_SP:   regs.depth_sp      = i_cfg_data[16:0];
                    CFG_SPEED_SP:   regs.speed_sp      = i_cfg_data[12:0];
                    CFG_HEADING_SP: regs.heading_sp    = i_cfg_data[14:0];
                    CFG_HEAD_GAIN:  regs.heading_gain  = i_cfg_data[15:0];
                    CFG_SPEED_GAIN: regs.speed_gain    = i_cfg_data[15:0];
                    CFG_DEPTH_GAIN: regs.depth_gain    = i_cfg_data[15:0];
                    CFG_HEAD_SHARE: regs.heading_share = i_cfg_data[8:0];
                    CFG_SPEED_SHR:  regs.speed_share   = i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
        o_pending = thrust_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the heading/speed/depth thrust mixer
// Drives directed and random sensor samples in bursts across several register
// settings; a checker beside the DUT predicts and compares every thrust result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsdtm_pkg::*;

    localparam int STAGES     = 16;
    // accept-to-strobe latency of the DUT
    localparam int LATENCY    = STAGES + 8;
    // cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    localparam real PI        = 3.14159265358979;

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  start              = 1'b0;
    logic                  busy;
    logic signed [15:0]    i_quat_w           = '0;
    logic signed [15:0]    i_quat_x           = '0;
    logic signed [15:0]    i_quat_y           = '0;
    logic signed [15:0]    i_quat_z           = '0;
    logic signed [16:0]    i_depth_measured   = '0;
    logic signed [12:0]    i_speed_measured   = '0;
    logic                  o_strobe;
    logic signed [15:0]    o_port_thrust;
    logic signed [15:0]    o_starboard_thrust;
    logic signed [15:0]    o_vertical_thrust;
    logic                  i_cfg_valid        = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // sender burst shaping
    int burst_left = 0;
    int max_gap    = 0;

    // setpoints currently loaded, used to aim measurements near them
    int cur_depth_sp   = 0;
    int cur_speed_sp   = 0;
    int cur_heading_sp = 0;

    always #5 i_clk = ~i_clk;

    heading_speed_depth_thrust_mixer #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_quat_w           (i_quat_w),
        .i_quat_x           (i_quat_x),
        .i_quat_y           (i_quat_y),
        .i_quat_z           (i_quat_z),
        .i_depth_measured   (i_depth_measured),
        .i_speed_measured   (i_speed_measured),
        .o_strobe           (o_strobe),
        .o_port_thrust      (o_port_thrust),
        .o_starboard_thrust (o_starboard_thrust),
        .o_vertical_thrust  (o_vertical_thrust),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    thrust_mix_checker #(
        .STAGES(STAGES)
    ) checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_quat_w           (i_quat_w),
        .i_quat_x           (i_quat_x),
        .i_quat_y           (i_quat_y),
        .i_quat_z           (i_quat_z),
        .i_depth_measured   (i_depth_measured),
        .i_speed_measured   (i_speed_measured),
        .i_strobe           (o_strobe),
        .i_port_thrust      (o_port_thrust),
        .i_starboard_thrust (o_starboard_thrust),
        .i_vertical_thrust  (o_vertical_thrust),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Watchdog: any sample, thrust or config transaction resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Symmetric random offset in [-half, half].
    function automatic int spread(int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    // Field extremes, zero, plus and minus one LSB, and the unit values of Q1.14.
    function automatic int pick_edge16();
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return 16384;
            default: return -16384;
        endcase
    endfunction

    // Present one sample and hold it until the transaction completes.
    // Sampling busy at the falling edge keeps the handshake free of races,
    // since the DUT only changes busy at the rising edge.
    task automatic send_sample(input int w, input int x, input int y, input int z,
                               input int dm, input int sm);
        // close the burst with an idle gap, then pick the next burst length
        if (burst_left == 0) begin
            if (max_gap > 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_quat_w         <= w[15:0];
        i_quat_x         <= x[15:0];
        i_quat_y         <= y[15:0];
        i_quat_z         <= z[15:0];
        i_depth_measured <= dm[16:0];
        i_speed_measured <= sm[12:0];
        start            <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Drop start and wait until every predicted thrust has come out, so the
    // registers can change without touching samples still in flight.
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // One config transaction; valid stays high so writes can run back to back.
    task automatic write_reg(input t_cfg_reg idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[16:0];
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic load_settings(input int depth_sp, input int speed_sp, input int heading_sp,
                                 input int head_gain, input int speed_gain, input int depth_gain,
                                 input int head_share, input int speed_share);
        write_reg(CFG_DEPTH_SP,   depth_sp);
        write_reg(CFG_SPEED_SP,   speed_sp);
        write_reg(CFG_HEADING_SP, heading_sp);
        write_reg(CFG_HEAD_GAIN,  head_gain);
        write_reg(CFG_SPEED_GAIN, speed_gain);
        write_reg(CFG_DEPTH_GAIN, depth_gain);
        write_reg(CFG_HEAD_SHARE, head_share);
        write_reg(CFG_SPEED_SHR,  speed_share);
        i_cfg_valid    <= 1'b0;
        cur_depth_sp   = depth_sp;
        cur_speed_sp   = speed_sp;
        cur_heading_sp = heading_sp;
    endtask

    // Random sample. Most are attitudes built from yaw/pitch/roll, so the
    // heading sweeps the whole circle and often sits near the half-turn flip;
    // the rest are raw bit patterns, field extremes and non-unit quaternions.
    task automatic send_random();
        int  mode, w, x, y, z, dm, sm;
        real yaw, pitch, roll, cy, sy, cp, sp, cr, sr;
        mode = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) begin
            dm = $urandom;
            sm = $urandom;
        end else begin
            dm = cur_depth_sp + spread(300);
            sm = cur_speed_sp + spread(300);
        end
        if (mode <= 5) begin
            if (mode == 5) begin
                yaw = cur_heading_sp / 64.0 + 180.0 + spread(100) / 64.0;
            end else begin
                yaw = $urandom_range(0, 3599999) / 10000.0;
            end
            if ($urandom_range(0, 1) == 0) begin
                pitch = 0.0;
                roll  = 0.0;
            end else begin
                pitch = spread(1000) / 100.0;
                roll  = spread(1000) / 100.0;
            end
            cy = $cos(yaw * PI / 360.0);
            sy = $sin(yaw * PI / 360.0);
            cp = $cos(pitch * PI / 360.0);
            sp = $sin(pitch * PI / 360.0);
            cr = $cos(roll * PI / 360.0);
            sr = $sin(roll * PI / 360.0);
            w = $rtoi(16384.0 * (cr * cp * cy + sr * sp * sy));
            x = $rtoi(16384.0 * (sr * cp * cy - cr * sp * sy));
            y = $rtoi(16384.0 * (cr * sp * cy + sr * cp * sy));
            z = $rtoi(16384.0 * (cr * cp * sy - sr * sp * cy));
            // q and -q are the same attitude
            if ($urandom_range(0, 1) == 1) begin
                w = -w;
                x = -x;
                y = -y;
                z = -z;
            end
        end else if (mode <= 7) begin
            w = $urandom;
            x = $urandom;
            y = $urandom;
            z = $urandom;
        end else if (mode == 8) begin
            w  = pick_edge16();
            x  = pick_edge16();
            y  = pick_edge16();
            z  = pick_edge16();
            dm = $urandom_range(0, 1) ? 65535 : -65536;
            sm = $urandom_range(0, 1) ? 4095 : -4096;
        end else begin
            w = spread(16384);
            x = spread(16384);
            y = spread(16384);
            z = spread(16384);
        end
        send_sample(w, x, y, z, dm, sm);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        max_gap = 4;

        // Directed samples under the reset register values.
        send_sample(16384, 0, 0, 0, 0, 0);               // identity, heading zero
        send_sample(0, 0, 8192, 8192, 100, -50);         // atan2 vector of zero length
        send_sample(5000, 5000, 8192, -8192, -100, 50);  // zero vector, other sign mix
        send_sample(16384, 0, 0, -1, 0, 0);              // just below a full turn, wraps to 0
        send_sample(0, 0, 0, 16384, 0, 0);               // half turn, negative denominator
        send_sample(11585, 0, 0, 11585, 0, 0);           // quarter turn
        send_sample(11585, 0, 0, -11585, 0, 0);          // three quarter turn
        send_sample(-3000, 0, 0, 16000, 0, 0);           // negative num and den
        send_sample(32767, 32767, 32767, 32767, 65535, 4095);
        send_sample(-32768, -32768, -32768, -32768, -65536, -4096);
        send_sample(-1, -1, -1, -1, -1, -1);
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(16384, -16384, 16384, -16384, 1234, -567);

        // Put the setpoint at half a turn to land the error on the flip boundary.
        drain();
        write_reg(CFG_HEADING_SP, HEAD_HALF);
        i_cfg_valid    <= 1'b0;
        cur_heading_sp = HEAD_HALF;
        send_sample(16384, 0, 0, 0, 0, 0);               // error exactly half a turn
        send_sample(16384, 0, 0, 2, 0, 0);               // error one step under
        send_sample(16384, 0, 0, -2, 0, 0);              // error one step under, negative
        send_sample(0, 0, 0, 16384, 0, 0);               // error near zero

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 9; phase++) begin
            drain();
            case (phase)
                0: load_settings(65535, 4095, 32767, 65535, 65535, 65535, 511, 511);
                1: load_settings(-65536, -4096, 0, 0, 0, 0, 0, 0);
                2: load_settings(1000, -200, 23039, 65535, 2560, 12800, 256, 256);
                3: load_settings(0, 0, 0, 256, 2560, 12800, 128, 128);
                default: begin
                    load_settings(spread(65536) - ($urandom_range(0, 1) ? 0 : 0),
                                  spread(4096),
                                  ($urandom_range(0, 4) == 0) ? $urandom_range(23040, 32767)
                                                              : $urandom_range(0, 23039),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 1023),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 4095),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 16383),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 256),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 256));
                end
            endcase
            // every third phase streams back to back with no idle gaps
            max_gap    = (phase % 3 == 1) ? 0 : $urandom_range(2, 12);
            burst_left = 0;
            repeat (120) send_random();
        end

        // Drain the pipeline, then leave room for any stray strobe.
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
